/* src/fwpp_pkg.sv */
// Shared constants and types for the framed word packet parser.
`timescale 1ns / 1ps

package fwpp_pkg;

  // Buffer depth default and the span cleared when a frame is dropped
  localparam int FRAME_MAX_DEF = 12;
  localparam int CLEAR_SPAN    = 10;

  // Words are read from buffer bytes 2..9
  localparam int WORD_BASE  = 2;
  localparam int WORD_BYTES = 8;

  // Register defaults
  localparam logic [7:0] FIRST_HEADER_RST  = 8'h2C;
  localparam logic [7:0] SECOND_HEADER_RST = 8'h12;
  localparam logic [7:0] END_MARKER_RST    = 8'h5B;

  // Register indexes
  localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [1:0] REG_END_MARKER    = 2'd2;

  // Four held values, value_zero in the lowest bits
  typedef struct packed {
    logic [15:0] value_three;
    logic [15:0] value_two;
    logic [15:0] value_one;
    logic [15:0] value_zero;
  } word_set_t;

endpackage

/* src/fwpp_word_merge.sv */
// Word assembly and held-value update for a committed frame.
`timescale 1ns / 1ps

module fwpp_word_merge
  import fwpp_pkg::*;
(
  input  logic [7:0] mid_bytes [WORD_BYTES],
  input  word_set_t  held,
  output word_set_t  merged
);

  logic [15:0] w0, w1, w2, w3;
  logic [15:0] n0, n1, n2, n3;

  // Little-endian words from the byte pairs
  assign w0 = {mid_bytes[1], mid_bytes[0]};
  assign w1 = {mid_bytes[3], mid_bytes[2]};
  assign w2 = {mid_bytes[5], mid_bytes[4]};
  assign w3 = {mid_bytes[7], mid_bytes[6]};

  // A zero word keeps the held value
  assign n0 = (w0 != 16'd0) ? w0 : held.value_zero;
  assign n1 = (w1 != 16'd0) ? w1 : held.value_one;
  assign n2 = (w2 != 16'd0) ? w2 : held.value_two;
  assign n3 = (w3 != 16'd0) ? w3 : held.value_three;

  // Zero third word: shift the first two up and zero the ends
  always_comb begin
    if (w2 == 16'd0) begin
      merged.value_zero  = 16'd0;
      merged.value_one   = n0;
      merged.value_two   = n1;
      merged.value_three = 16'd0;
    end else begin
      merged.value_zero  = n0;
      merged.value_one   = n1;
      merged.value_two   = n2;
      merged.value_three = n3;
    end
  end

endmodule

/* src/framed_word_packet_parser_core.sv */
// Top level of the framed word packet parser: header hunt, frame buffer, commit.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_*       | in        | s_tvalid / s_tready     | s_tdata[7:0] = rx_byte
//  m_*       | out       | m_tvalid / m_tready     | m_tdata = value_zero..value_three
//  cfg_*     | in        | cfg_we (no back-press.) | cfg_index, cfg_data[7:0]
//
// One word is taken per cycle while s_tready is high; each word is handled in the
// cycle it arrives and a commit shows its result on m_* from the next cycle.
// The held values double as the output register, so only the check word of a
// frame can stall: s_tready drops in that phase while a result waits unaccepted.
// Reset (rst, synchronous) zeroes the buffer and the held values and sets the
// registers to their defaults; no clearing pass follows.
`timescale 1ns / 1ps

module framed_word_packet_parser_core
  import fwpp_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] value_zero, [31:16] value_one,
                                 // [47:32] value_two, [63:48] value_three
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = $clog2(FRAME_MAX);
  localparam int CNT_W = $clog2(FRAME_MAX + 1);

  // Parser phases
  localparam logic [1:0] PH_HUNT1 = 2'd0;
  localparam logic [1:0] PH_HUNT2 = 2'd1;
  localparam logic [1:0] PH_STORE = 2'd2;
  localparam logic [1:0] PH_CHECK = 2'd3;

  logic [7:0] first_header;
  logic [7:0] second_header;
  logic [7:0] end_marker;

  logic [1:0]       phase, phase_next;
  logic [CNT_W-1:0] count, count_next, count_inc;
  logic [7:0]       frame_bytes [FRAME_MAX];
  word_set_t        held, merged;

  logic             accept;
  logic             store_en, abort_en, commit_en;
  logic [IDX_W-1:0] last_idx;
  logic             marker_ok;
  logic [7:0]       mid_bytes [WORD_BYTES];

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= FIRST_HEADER_RST;
      second_header <= SECOND_HEADER_RST;
      end_marker    <= END_MARKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_HEADER:  first_header  <= cfg_data;
        REG_SECOND_HEADER: second_header <= cfg_data;
        REG_END_MARKER:    end_marker    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the input off in reset, and hold the check word back only while a
  // finished result is still unread
  assign s_tready = !rst && !((phase == PH_CHECK) && m_tvalid && !m_tready);
  assign accept   = s_tvalid && s_tready;

  assign count_inc = count + CNT_W'(1);
  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign marker_ok = (frame_bytes[last_idx] == end_marker);

  // Phase decisions for the incoming word
  always_comb begin
    phase_next = phase;
    count_next = count;
    store_en   = 1'b0;
    abort_en   = 1'b0;
    commit_en  = 1'b0;
    case (phase)
      PH_HUNT1: begin
        if (s_tdata == first_header) begin
          store_en   = 1'b1;
          phase_next = PH_HUNT2;
        end else begin
          abort_en = 1'b1;
        end
      end
      PH_HUNT2: begin
        if (s_tdata == second_header) begin
          store_en   = 1'b1;
          phase_next = PH_STORE;
        end else begin
          abort_en = 1'b1;
        end
      end
      PH_STORE: begin
        store_en = 1'b1;
        // Close on the marker or a full buffer
        if ((count_inc >= CNT_W'(FRAME_MAX)) || (s_tdata == end_marker)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // Check word value is ignored; only the last stored byte matters
        if (marker_ok) begin
          commit_en  = 1'b1;
          phase_next = PH_HUNT1;
          count_next = '0;
        end else begin
          abort_en = 1'b1;
        end
      end
      default: abort_en = 1'b1;
    endcase
    if (store_en) begin
      count_next = count_inc;
    end
    if (abort_en) begin
      phase_next = PH_HUNT1;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT1;
      count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Frame buffer: drop clears the low span, good frames leave stale bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAME_MAX; k++) begin
        frame_bytes[k] <= 8'd0;
      end
    end else if (accept) begin
      if (abort_en) begin
        for (int k = 0; k < FRAME_MAX; k++) begin
          if (k < CLEAR_SPAN) begin
            frame_bytes[k] <= 8'd0;
          end
        end
      end else if (store_en && (count < CNT_W'(FRAME_MAX))) begin
        frame_bytes[count[IDX_W-1:0]] <= s_tdata;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < WORD_BYTES; k++) begin
      mid_bytes[k] = frame_bytes[WORD_BASE + k];
    end
  end

  fwpp_word_merge u_merge (
    .mid_bytes (mid_bytes),
    .held      (held),
    .merged    (merged)
  );

  // Held values are the output payload; they only move on a commit
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept && commit_en) begin
      held <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && commit_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = held;

  // Hunting for the first header always starts from an empty buffer count
  a_hunt1_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT1) |-> (count == '0))
    else $error("count not zero while hunting first header");

  // One header byte stored while waiting for the second
  a_hunt2_one: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT2) |-> (count == CNT_W'(1)))
    else $error("count not one while hunting second header");

  // Storing never reaches the buffer bound without moving to the check phase
  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STORE) |-> (count >= CNT_W'(2)) && (count < CNT_W'(FRAME_MAX)))
    else $error("count out of range while storing");

  // A committed frame raises a result and restarts the hunt
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    (accept && commit_en) |=> (m_tvalid && (phase == PH_HUNT1) && (count == '0)))
    else $error("commit did not raise a result");

  // Held values change only through a commit
  a_held_commit: assert property (@(posedge clk) disable iff (rst)
    !(accept && commit_en) |=> $stable(held))
    else $error("held values moved without a commit");

endmodule

/* test/framed_word_packet_parser_core_tb.sv */
// Self-checking testbench for the framed word packet parser: random frames in, held values out.
`timescale 1ns / 1ps

module framed_word_packet_parser_core_tb;
  import fwpp_pkg::*;

  localparam int FRAME_DEPTH   = FRAME_MAX_DEF;
  localparam int PHASE_WORDS   = 270;     // random words per register setting
  localparam int SETTLE_CYCLES = 4;       // a commit shows in the cycle after its check word
  localparam int HOLD_AFTER    = 10;      // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  // cfg_index 3 addresses no register; the block must ignore it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    STORING,
    AWAIT_CHECK
  } parse_phase_e;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;             // [15:0] value_zero, [31:16] value_one,
                                    // [47:32] value_two, [63:48] value_three
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_FIRST_HEADER;
  logic [7:0]  cfg_data  = 8'h00;

  framed_word_packet_parser_core #(
    .FRAME_MAX (FRAME_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: own copy of the registers, the buffer and the held values
  // ---------------------------------------------------------------------------
  logic [7:0]   hdr_first  = FIRST_HEADER_RST;
  logic [7:0]   hdr_second = SECOND_HEADER_RST;
  logic [7:0]   end_mark   = END_MARKER_RST;
  parse_phase_e phase_q    = HUNT_FIRST;
  logic [3:0]   stored_cnt = 4'd0;
  logic [7:0]   frame_buf [FRAME_DEPTH];
  logic [15:0]  held [4];

  logic [7:0]   rx_backlog [$];     // words still to be offered, front one on the bus
  word_set_t    value_sets [$];     // held-value sets still owed by the block

  string        field_names [4] = '{"value_zero", "value_one", "value_two", "value_three"};

  bit           failed       = 1'b0;
  bit           word_taken   = 1'b0;
  int           results_seen = 0;
  int           cycle_count  = 0;

  function automatic logic [7:0] buf_byte(input int idx);
    return (idx < FRAME_DEPTH) ? frame_buf[idx] : 8'h00;
  endfunction

  task automatic store_rx_byte(input logic [7:0] b);
    if (stored_cnt < FRAME_DEPTH) frame_buf[stored_cnt] = b;
    stored_cnt = stored_cnt + 4'd1;
  endtask

  // Advance the mirror by one received word; queue a held-value set on commit
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [15:0] w;
    logic [15:0] t;
    bit          gap;
    word_set_t   res;
    gap = 1'b0;
    if (phase_q == HUNT_FIRST && b == hdr_first) begin
      phase_q = HUNT_SECOND;
      store_rx_byte(b);
    end else if (phase_q == HUNT_SECOND && b == hdr_second) begin
      phase_q = STORING;
      store_rx_byte(b);
    end else if (phase_q == STORING) begin
      store_rx_byte(b);
      if (stored_cnt >= FRAME_DEPTH || b == end_mark) phase_q = AWAIT_CHECK;
    end else if (phase_q == AWAIT_CHECK && stored_cnt != 0 &&
                 buf_byte(int'(stored_cnt) - 1) == end_mark) begin
      // Commit: little-endian words from buffer bytes 2..9, zero words keep old value
      for (int k = 0; k < 4; k++) begin
        w = {buf_byte(WORD_BASE + 2 * k + 1), buf_byte(WORD_BASE + 2 * k)};
        if (w != 16'h0000) held[k] = w;
        else if (k == 2) gap = 1'b1;
      end
      // A zero third word shifts the pair up and clears both ends
      if (gap) begin
        t       = held[1];
        held[1] = held[0];
        held[2] = t;
        held[0] = 16'h0000;
        held[3] = 16'h0000;
      end
      phase_q    = HUNT_FIRST;
      stored_cnt = 4'd0;
      res.value_zero  = held[0];
      res.value_one   = held[1];
      res.value_two   = held[2];
      res.value_three = held[3];
      value_sets.push_back(res);
    end else begin
      // Wrong header or missing marker: drop the frame and clear the front of the buffer
      phase_q    = HUNT_FIRST;
      stored_cnt = 4'd0;
      for (int k = 0; k < CLEAR_SPAN && k < FRAME_DEPTH; k++) frame_buf[k] = 8'h00;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Payload byte biased towards zero and all-ones, never the end marker
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      b = 8'h00;
    else if (pick < 35) b = 8'hFF;
    else                b = 8'($urandom_range(0, 255));
    if (b == end_mark) b = b ^ 8'h01;
    return b;
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic queue_frame();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      rx_backlog.push_back(hdr_first);
      rx_backlog.push_back(hdr_second);
      if (pick < 70) begin
        len = $urandom_range(0, FRAME_DEPTH - 3);
        for (int k = 0; k < len; k++) rx_backlog.push_back(payload_byte());
        rx_backlog.push_back(end_mark);
      end else begin
        // fill the buffer with no marker in it
        for (int k = 0; k < FRAME_DEPTH - 2; k++) rx_backlog.push_back(payload_byte());
      end
      rx_backlog.push_back(8'($urandom_range(0, 255)));   // check word, value ignored
    end else if (pick < 90) begin
      rx_backlog.push_back(hdr_first);
      rx_backlog.push_back(hdr_second ^ 8'($urandom_range(1, 255)));
    end else begin
      rx_backlog.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random_words(input int count);
    int stop_at;
    stop_at = rx_backlog.size() + count;
    while (rx_backlog.size() < stop_at) queue_frame();
  endtask

  // Write one register, meant for use while the parser is idle (the task does not enforce it); the mirror follows
  task automatic program_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_FIRST_HEADER:  hdr_first  = val;
      REG_SECOND_HEADER: hdr_second = val;
      REG_END_MARKER:    end_mark   = val;
      default: ;
    endcase
  endtask

  // Wait for every word to go in and every owed set to come out, then let the
  // tail of a frame that gives no result finish inside the block
  task automatic settle();
    while (rx_backlog.size() != 0 || value_sets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, valid held until taken
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    bit was_taken;
    was_taken = word_taken;
    if (word_taken) begin
      void'(rx_backlog.pop_front());
      word_taken = 1'b0;
    end
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !was_taken) begin
      // hold the offered word until the block takes it
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (rx_backlog.size() != 0) begin
      s_tvalid <= 1'b1;
      s_tdata  <= rx_backlog[0];
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: free-running window, then random stalls; one long hold-off
  // ---------------------------------------------------------------------------
  int  ready_step = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      // starve the output so the check word backs up into the input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else begin
      ready_step = (ready_step + 1) % 48;
      m_tready <= (ready_step < 16) || ($urandom_range(0, 1) == 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest owed set, then feed
  // each taken input word to the mirror
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_set_t   want;
    logic [63:0] want_bits;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (value_sets.size() == 0) begin
          $error("result %h with no held-value set owed", m_tdata);
          failed = 1'b1;
        end else begin
          want      = value_sets.pop_front();
          want_bits = want;
          for (int k = 0; k < 4; k++) begin
            if (want_bits[16 * k +: 16] !== m_tdata[16 * k +: 16]) begin
              $error("%s: expected %h, actual %h", field_names[k],
                     want_bits[16 * k +: 16], m_tdata[16 * k +: 16]);
              failed = 1'b1;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
        word_taken = 1'b1;
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frames at reset values, then random traffic under
  // several register settings
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < FRAME_DEPTH; k++) frame_buf[k] = 8'h00;
    for (int k = 0; k < 4; k++) held[k] = 16'h0000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rx_backlog = {
      // wrong first header, then wrong second header
      8'h00, FIRST_HEADER_RST, 8'h07,
      // full buffer with no marker: check word equal to the marker is still dropped
      FIRST_HEADER_RST, SECOND_HEADER_RST,
      8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'h33,
      END_MARKER_RST,
      // short frame, all-ones word, zero third word shifts the held values
      FIRST_HEADER_RST, SECOND_HEADER_RST, 8'hFF, 8'hFF, END_MARKER_RST, 8'h00,
      // shorter frame reads leftover bytes from the one before
      FIRST_HEADER_RST, SECOND_HEADER_RST, END_MARKER_RST, 8'hA7
    };
    queue_random_words(PHASE_WORDS);

    for (int phase_no = 1; phase_no <= 4; phase_no++) begin
      settle();
      case (phase_no)
        1: begin
          program_reg(REG_FIRST_HEADER, 8'h00);
          program_reg(REG_SECOND_HEADER, 8'hFF);
          program_reg(REG_END_MARKER, 8'h00);
        end
        2: begin
          program_reg(REG_FIRST_HEADER, 8'hFF);
          program_reg(REG_SECOND_HEADER, 8'h00);
          program_reg(REG_END_MARKER, 8'hFF);
          program_reg(REG_UNUSED, 8'hA5);
        end
        3: begin
          // headers and marker all alike
          program_reg(REG_FIRST_HEADER, 8'h80);
          program_reg(REG_SECOND_HEADER, 8'h80);
          program_reg(REG_END_MARKER, 8'h80);
        end
        default: begin
          program_reg(REG_FIRST_HEADER, 8'($urandom_range(0, 255)));
          program_reg(REG_SECOND_HEADER, 8'($urandom_range(0, 255)));
          program_reg(REG_END_MARKER, 8'($urandom_range(0, 255)));
          program_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        end
      endcase
      queue_random_words(PHASE_WORDS);
    end

    settle();
    if (!failed && value_sets.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
